// ===== rtl/gpf_pkg.sv =====
// ============================================================================
// gpf_pkg
// Shared types and constants of the grid phase factor sine/cosine core.
// ============================================================================
`default_nettype none

package gpf_pkg;

    // Field widths
    localparam int COORD_W = 7;
    localparam int STEP_W  = 32;
    localparam int GRID_W  = 7;
    localparam int VALUE_W = 16;
    localparam int INDEX_W = 18;

    // Pipeline: stage 0 input word, stage 1 phase and index, 2..7 sine/cosine
    localparam int NUM_STAGES = 8;
    localparam int LAST_STAGE = NUM_STAGES - 1;

    // Register indexes of the configuration port
    localparam int             REG_IDX_W     = 2;
    localparam logic [1:0]     REG_GRID_SIZE = 2'd0;
    localparam logic [1:0]     REG_STEP_X    = 2'd1;
    localparam logic [1:0]     REG_STEP_Y    = 2'd2;
    localparam logic [1:0]     REG_STEP_Z    = 2'd3;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd32;

    // Quarter turn as a 32-bit phase
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Q2.30 Taylor terms of sin(pi/2*z)
    localparam int T3_W = 23;
    localparam int T2_W = 27;
    localparam int T1_W = 30;
    localparam int T0_W = 31;
    localparam logic [T0_W-1:0] SC_C0 = 31'd1686629713;
    localparam logic [T1_W-1:0] SC_C1 = 30'd693598668;
    localparam logic [T2_W-1:0] SC_C2 = 27'd85569306;
    localparam logic [T3_W-1:0] SC_C3 = 23'd5026995;
    localparam logic [17:0]     SC_C4 = 18'd172272;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 16'd32767;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [INDEX_W-1:0]        index_t;

    // Pipeline control shared by the stages
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;   // stage takes a new word this cycle
        logic [NUM_STAGES-1:0] valid;  // stage holds a word
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/gpf_pipe_ctrl.sv =====
// ============================================================================
// gpf_pipe_ctrl
// Valid bits and load enables of the elastic pipeline; bubbles collapse.
// ============================================================================
`default_nettype none

module gpf_pipe_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic             out_ready,
    output      gpf_pkg::pipe_ctl_t ctl
);
    import gpf_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] space;
    logic [NUM_STAGES-1:0] load;

    // A stage has room when it is empty or its word moves on
    always_comb
    begin
        space[LAST_STAGE] = !valid_reg[LAST_STAGE] || out_ready;
        for (int s = LAST_STAGE - 1; s >= 0; s--)
        begin
            space[s] = !valid_reg[s] || space[s + 1];
        end
    end

    always_comb
    begin
        load[0]       = in_valid && space[0];
        valid_next[0] = space[0] ? in_valid : valid_reg[0];
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            load[s]       = valid_reg[s - 1] && space[s];
            valid_next[s] = space[s] ? valid_reg[s - 1] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = space[0];
    assign ctl.load  = load;
    assign ctl.valid = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/gpf_index.sv =====
// ============================================================================
// gpf_index
// Range check, wrap of negative coordinates and linear index of one point.
// ============================================================================
`default_nettype none

module gpf_index #(
    parameter int MAX_GRID = 64
) (
    input  wire gpf_pkg::coord_t                      coord_x,
    input  wire gpf_pkg::coord_t                      coord_y,
    input  wire gpf_pkg::coord_t                      coord_z,
    input  wire logic [$clog2(MAX_GRID + 1)-1:0]      grid_n,
    input  wire logic [2*$clog2(MAX_GRID + 1)-1:0]    grid_nn,
    output      gpf_pkg::index_t                      linear_index,
    output      logic                                 out_of_range
);
    import gpf_pkg::*;

    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int CW = (NW + 2 > COORD_W + 1) ? NW + 2 : COORD_W + 1;
    localparam int SW = (3 * NW + 2 > INDEX_W) ? 3 * NW + 2 : INDEX_W;

    logic signed [CW-1:0] c_ext [3];
    logic signed [CW-1:0] c_wrap [3];
    logic [NW-1:0]        w [3];
    logic [2:0]           axis_oor;
    logic signed [CW-1:0] n_s;
    logic signed [CW-1:0] half_s;
    logic [SW-1:0]        sum;

    // Per-axis check and wrap
    always_comb
    begin
        n_s      = signed'(CW'(grid_n));
        half_s   = signed'(CW'(grid_n >> 1));
        c_ext[0] = CW'(coord_x);
        c_ext[1] = CW'(coord_y);
        c_ext[2] = CW'(coord_z);
        for (int a = 0; a < 3; a++)
        begin
            axis_oor[a] = (c_ext[a] > half_s) || (c_ext[a] < -half_s);
            c_wrap[a]   = (c_ext[a] < 0) ? c_ext[a] + n_s : c_ext[a];
            w[a]        = c_wrap[a][NW-1:0];
        end
    end

    // x1*n*n + y1*n + z1, low bits kept
    always_comb
    begin
        sum = SW'(w[0]) * SW'(grid_nn) + SW'(w[1]) * SW'(grid_n) + SW'(w[2]);
        out_of_range = |axis_oor;
        linear_index = out_of_range ? '0 : sum[INDEX_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/gpf_sincos.sv =====
// ============================================================================
// gpf_sincos
// Pipelined Q1.15 sine of a 32-bit turn fraction, stages 2 to 7.
// ============================================================================
`default_nettype none

module gpf_sincos (
    input  wire logic               clk,
    input  wire gpf_pkg::pipe_ctl_t ctl,
    input  wire logic [31:0]        phase,
    output      gpf_pkg::value_t    value
);
    import gpf_pkg::*;

    // Stage 2: fold into quadrant, square
    logic [1:0]      quad;
    logic [30:0]     f;
    logic [30:0]     z_next;
    logic [61:0]     zz;
    logic            neg2_reg, neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [30:0]     z2_reg, z3_reg, z4_reg, z5_reg, z6_reg;
    logic [30:0]     sq2_reg, sq3_reg, sq4_reg, sq5_reg;
    logic [T3_W-1:0] t3_reg;
    logic [T2_W-1:0] t2_reg;
    logic [T1_W-1:0] t1_reg;
    logic [T0_W-1:0] t0_reg;
    logic [48:0]     p3;
    logic [53:0]     p2;
    logic [57:0]     p1;
    logic [60:0]     p0;
    logic [61:0]     pr;
    logic [32:0]     rnd;
    logic [17:0]     mag;
    logic [VALUE_W-1:0] mag_sat;
    logic [VALUE_W-1:0] value_next;
    logic [VALUE_W-1:0] value_reg;

    always_comb
    begin
        quad   = phase[31:30];
        f      = {1'b0, phase[29:0]};
        z_next = quad[0] ? (31'h4000_0000 - f) : f;
        zz     = 62'(z_next) * 62'(z_next);
    end

    // Horner chain, one product per stage
    always_comb
    begin
        p3 = 49'(sq2_reg) * 49'(SC_C4);
        p2 = 54'(sq3_reg) * 54'(t3_reg);
        p1 = 58'(sq4_reg) * 58'(t2_reg);
        p0 = 61'(sq5_reg) * 61'(t1_reg);
    end

    // Stage 7: final product, rounding, saturation, sign
    always_comb
    begin
        pr         = 62'(z6_reg) * 62'(t0_reg);
        rnd        = {1'b0, pr[61:30]} + 33'd16384;
        mag        = rnd[32:15];
        mag_sat    = (mag > 18'(VALUE_MAX)) ? VALUE_MAX : mag[VALUE_W-1:0];
        value_next = neg6_reg ? (~mag_sat + 16'd1) : mag_sat;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            neg2_reg <= quad[1];
            z2_reg   <= z_next;
            sq2_reg  <= zz[60:30];
        end
        if (ctl.load[3])
        begin
            neg3_reg <= neg2_reg;
            z3_reg   <= z2_reg;
            sq3_reg  <= sq2_reg;
            t3_reg   <= SC_C3 - T3_W'(p3 >> 30);
        end
        if (ctl.load[4])
        begin
            neg4_reg <= neg3_reg;
            z4_reg   <= z3_reg;
            sq4_reg  <= sq3_reg;
            t2_reg   <= SC_C2 - T2_W'(p2 >> 30);
        end
        if (ctl.load[5])
        begin
            neg5_reg <= neg4_reg;
            z5_reg   <= z4_reg;
            sq5_reg  <= sq4_reg;
            t1_reg   <= SC_C1 - T1_W'(p1 >> 30);
        end
        if (ctl.load[6])
        begin
            neg6_reg <= neg5_reg;
            z6_reg   <= z5_reg;
            t0_reg   <= SC_C0 - T0_W'(p0 >> 30);
        end
        if (ctl.load[7])
        begin
            value_reg <= value_next;
        end
    end

    assign value = signed'(value_reg);

endmodule

`default_nettype wire

// ===== rtl/grid_phase_factor_sincos_core.sv =====
// ============================================================================
// grid_phase_factor_sincos_core
// Sine and cosine of a cubic-grid point's plane-wave phase, with its
// wrapped linear index and a range flag.
// ============================================================================
//
//  channel   dir  handshake                word
//  s_axis    in   s_tvalid / s_tready      coord_x, coord_y, coord_z
//  m_axis    out  m_tvalid / m_tready      sine, cosine, index; tuser range flag
//  cfg       in   cfg_valid / cfg_ready    register index, 32-bit data
//
//  One word per cycle sustained while m_tready stays high; words pass stages 0 to 7.
//  The depth is set by the sine/cosine Horner chain, one multiply per stage.
//  Stages load independently, so bubbles close up and a stalled output
//  still lets earlier stages fill. cfg_ready is always high.
//  Reset clears the valid bits and loads the register reset values.
// ============================================================================
`default_nettype none

module grid_phase_factor_sincos_core #(
    parameter int MAX_GRID = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // coord_x[6:0], coord_y[13:7], coord_z[20:14], 0
    // result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [55:0] m_tdata,   // sine[15:0], cosine[31:16], index[49:32], 0
    output      logic [0:0]  m_tuser    // out_of_range[0]
);
    import gpf_pkg::*;

    localparam int NW      = $clog2(MAX_GRID + 1);
    localparam int RESET_N = (32 > MAX_GRID) ? MAX_GRID : 32;

    pipe_ctl_t           ctl;

    logic [GRID_W-1:0]   grid_size_reg;
    logic [STEP_W-1:0]   step_x_reg;
    logic [STEP_W-1:0]   step_y_reg;
    logic [STEP_W-1:0]   step_z_reg;
    logic [NW-1:0]       grid_n;
    logic [2*NW-1:0]     grid_nn_reg;

    coord_t              cx_reg, cy_reg, cz_reg;
    logic [31:0]         phase_next;
    logic [31:0]         phase_reg;
    logic [31:0]         cos_phase;
    index_t              index_next;
    logic                oor_next;
    index_t              idx_pipe_reg [1:LAST_STAGE];
    logic                oor_pipe_reg [1:LAST_STAGE];
    value_t              sine_value;
    value_t              cosine_value;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_RESET;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            step_z_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GRID_SIZE: grid_size_reg <= cfg_data[GRID_W-1:0];
                REG_STEP_X:    step_x_reg    <= cfg_data;
                REG_STEP_Y:    step_y_reg    <= cfg_data;
                REG_STEP_Z:    step_z_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Effective grid size, clamped to 1..MAX_GRID
    always_comb
    begin
        if (grid_size_reg == '0)
        begin
            grid_n = NW'(1);
        end
        else if (32'(grid_size_reg) > MAX_GRID)
        begin
            grid_n = NW'(MAX_GRID);
        end
        else
        begin
            grid_n = NW'(grid_size_reg);
        end
    end

    // Registered n*n, updated from the grid size on the next clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_nn_reg <= (2*NW)'(RESET_N * RESET_N);
        end
        else
        begin
            grid_nn_reg <= (2*NW)'(grid_n) * (2*NW)'(grid_n);
        end
    end

    gpf_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    // Stage 1: phase sum mod 2^32
    always_comb
    begin
        phase_next = step_x_reg * 32'(cx_reg)
                   + step_y_reg * 32'(cy_reg)
                   + step_z_reg * 32'(cz_reg);
    end

    gpf_index #(
        .MAX_GRID (MAX_GRID)
    ) u_index (
        .coord_x      (cx_reg),
        .coord_y      (cy_reg),
        .coord_z      (cz_reg),
        .grid_n       (grid_n),
        .grid_nn      (grid_nn_reg),
        .linear_index (index_next),
        .out_of_range (oor_next)
    );

    // Input word, phase and index pipeline
    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            cx_reg <= signed'(s_tdata[6:0]);
            cy_reg <= signed'(s_tdata[13:7]);
            cz_reg <= signed'(s_tdata[20:14]);
        end
        if (ctl.load[1])
        begin
            phase_reg       <= phase_next;
            idx_pipe_reg[1] <= index_next;
            oor_pipe_reg[1] <= oor_next;
        end
        for (int s = 2; s < NUM_STAGES; s++)
        begin
            if (ctl.load[s])
            begin
                idx_pipe_reg[s] <= idx_pipe_reg[s - 1];
                oor_pipe_reg[s] <= oor_pipe_reg[s - 1];
            end
        end
    end

    assign cos_phase = phase_reg + QUARTER_TURN;

    gpf_sincos u_sine (
        .clk   (clk),
        .ctl   (ctl),
        .phase (phase_reg),
        .value (sine_value)
    );

    gpf_sincos u_cosine (
        .clk   (clk),
        .ctl   (ctl),
        .phase (cos_phase),
        .value (cosine_value)
    );

    // Result word
    assign m_tvalid = ctl.valid[LAST_STAGE];
    assign m_tdata  = {6'b0, idx_pipe_reg[LAST_STAGE], cosine_value, sine_value};
    assign m_tuser  = oor_pipe_reg[LAST_STAGE];

endmodule

`default_nettype wire

// ===== verif/tb_grid_phase_factor_sincos_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_grid_phase_factor_sincos_core
// Self-checking bench for the grid phase factor sine/cosine core. Grid points
// stream in with random gaps, and results are drained under random
// back-pressure, including one long hold-off that fills the pipeline.
// A scoreboard works out sine, cosine, wrapped index and range flag for
// every accepted point and compares them, in order, with each result word.
// Several register settings are exercised, including size and step extremes.
// ============================================================================

module tb_grid_phase_factor_sincos_core;

    import gpf_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 64;
    localparam int NUM_PHASES      = 10;
    localparam int POINTS_PER_PHASE = 45;
    localparam int MAX_REPORTS     = 10;
    localparam int MAX_GRID_TB     = 64;

    // One expected result word
    typedef struct packed {
        logic [VALUE_W-1:0] sine;
        logic [VALUE_W-1:0] cosine;
        index_t             index;
        logic               oor;
    } grid_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers, queue of pending results
    // ------------------------------------------------------------------------
    class phase_factor_scoreboard;
        logic [GRID_W-1:0] grid_size;
        logic [31:0]       step_x;
        logic [31:0]       step_y;
        logic [31:0]       step_z;
        grid_result_t      expected_q[$];
        int                errors;
        int                reported;

        function new();
            grid_size = GRID_RESET;
            step_x    = '0;
            step_y    = '0;
            step_z    = '0;
            errors    = 0;
            reported  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_GRID_SIZE: grid_size = data[GRID_W-1:0];
                REG_STEP_X:    step_x    = data;
                REG_STEP_Y:    step_y    = data;
                REG_STEP_Z:    step_z    = data;
                default:       ;
            endcase
        endfunction

        // Polynomial sine of a 32-bit turn fraction, Q1.15 bit pattern
        function logic [VALUE_W-1:0] turn_sine(logic [31:0] turn);
            longint unsigned z;
            longint unsigned z2;
            longint unsigned t;
            longint unsigned r;
            logic [VALUE_W-1:0] mag;
            z = turn[29:0];
            if (turn[30])
                z = 64'h4000_0000 - z;
            z2 = (z * z) >> 30;
            t = SC_C4;
            t = SC_C3 - ((z2 * t) >> 30);
            t = SC_C2 - ((z2 * t) >> 30);
            t = SC_C1 - ((z2 * t) >> 30);
            t = SC_C0 - ((z2 * t) >> 30);
            r = (z * t) >> 30;
            r = (r + 64'd16384) >> 15;
            if (r > 64'd32767)
                r = 64'd32767;
            mag = r[VALUE_W-1:0];
            return turn[31] ? -mag : mag;
        endfunction

        function void note_point(coord_t cx, coord_t cy, coord_t cz);
            int            x;
            int            y;
            int            z;
            int            n;
            int            half;
            logic [31:0]   turn;
            grid_result_t  want;
            x = cx;
            y = cy;
            z = cz;
            n = grid_size;
            if (n < 1)
                n = 1;
            if (n > MAX_GRID_TB)
                n = MAX_GRID_TB;
            half = n / 2;
            turn = step_x * 32'(x) + step_y * 32'(y) + step_z * 32'(z);
            want.sine   = turn_sine(turn);
            want.cosine = turn_sine(turn + QUARTER_TURN);
            want.oor    = (x > half || x < -half || y > half || y < -half ||
                           z > half || z < -half);
            want.index  = '0;
            if (!want.oor)
            begin
                if (x < 0) x += n;
                if (y < 0) y += n;
                if (z < 0) z += n;
                want.index = index_t'(x * n * n + y * n + z);
            end
            expected_q.push_back(want);
        endfunction

        function void check_word(logic [55:0] data, logic [0:0] user);
            grid_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("unexpected result word: data %h user %b", data, user);
                end
                return;
            end
            want = expected_q.pop_front();
            if (data[15:0] !== want.sine || data[31:16] !== want.cosine ||
                data[49:32] !== want.index || user[0] !== want.oor)
            begin
                errors++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("mismatch: sine %h/%h cosine %h/%h index %0d/%0d oor %b/%b",
                             want.sine, data[15:0], want.cosine, data[31:16],
                             want.index, data[49:32], want.oor, user[0]);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // coord_x[6:0], coord_y[13:7], coord_z[20:14], 0
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // sine[15:0], cosine[31:16], index[49:32], 0
    logic [0:0]  m_tuser;   // out_of_range[0]

    phase_factor_scoreboard sb;
    int unsigned cycle_count;
    int          sender_idle_pct;
    int          stall_pct;
    bit          hold_request;

    grid_phase_factor_sincos_core #(
        .MAX_GRID (MAX_GRID_TB)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock, 8 ns period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sample handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_point(s_tdata[6:0], s_tdata[13:7], s_tdata[20:14]);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tuser);
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(input coord_t cx, input coord_t cy, input coord_t cz);
        int burst;
        if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct)
        begin
            burst = $urandom_range(1, 8);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (burst - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cz, cy, cx};
        do @(posedge clk); while (!s_tready);
    endtask

    // Stop offering words and let every pending result come out
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (NUM_STAGES) @(negedge clk);
    endtask

    // Step values: random, quarter-turn multiples, small, small negative
    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return QUARTER_TURN * $urandom_range(0, 3);
            2:       return $urandom_range(0, 255);
            default: return -$urandom_range(0, 255);
        endcase
    endfunction

    // Mostly inside the grid, sometimes anywhere in the 7-bit range
    function automatic coord_t pick_coord(int half);
        if ($urandom_range(0, 99) < 12)
            return coord_t'($urandom_range(0, 127));
        return coord_t'($urandom_range(0, 2 * half) - half);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [GRID_W-1:0] grid_list [NUM_PHASES];
        int                n;
        int                half;
        int                leftover;

        grid_list = '{7'd2, 7'd64, 7'd1, 7'd3, 7'd0, 7'd127, 7'd17, 7'd8,
                      7'd64, 7'd32};
        sb              = new();
        cycle_count     = 0;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_GRID_SIZE;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_request    = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, zero phase, edge of the default grid
        send_point(7'sd0, 7'sd0, 7'sd0);
        send_point(7'sd16, -7'sd16, 7'sd5);
        send_point(-7'sd17, 7'sd0, 7'sd16);
        drain();

        // Quarter-turn peaks, step of minus one, half-turn step, extremes
        write_reg(REG_GRID_SIZE, 32'd64);
        write_reg(REG_STEP_X, QUARTER_TURN);
        write_reg(REG_STEP_Y, 32'hFFFF_FFFF);
        write_reg(REG_STEP_Z, 32'h8000_0000);
        send_point(7'sd1, 7'sd0, 7'sd0);
        send_point(-7'sd1, 7'sd0, 7'sd0);
        send_point(7'sd2, 7'sd0, 7'sd0);
        send_point(7'sd0, 7'sd1, 7'sd1);
        send_point(7'sd32, -7'sd32, 7'sd32);
        send_point(-7'sd32, 7'sd32, -7'sd32);
        send_point(7'sd63, -7'sd64, 7'sd0);
        send_point(7'sd0, 7'sd33, -7'sd33);
        drain();

        // Grid size zero acts as one
        write_reg(REG_GRID_SIZE, 32'd0);
        send_point(7'sd0, 7'sd0, 7'sd0);
        send_point(7'sd1, 7'sd0, 7'sd0);
        send_point(7'sd0, 7'sd0, -7'sd1);
        drain();

        // Oversized grid clamps to the largest
        write_reg(REG_GRID_SIZE, 32'd127);
        write_reg(REG_STEP_X, 32'd0);
        write_reg(REG_STEP_Z, 32'h1234_5679);
        send_point(7'sd31, -7'sd5, 7'sd7);
        send_point(-7'sd32, -7'sd1, 7'sd32);
        send_point(7'sd32, 7'sd33, -7'sd64);
        drain();

        // Random phases; the last two run with no idling on either side
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_GRID_SIZE, 32'(grid_list[p]));
            write_reg(REG_STEP_X, pick_step());
            write_reg(REG_STEP_Y, pick_step());
            write_reg(REG_STEP_Z, pick_step());
            n = grid_list[p];
            if (n < 1)
                n = 1;
            if (n > MAX_GRID_TB)
                n = MAX_GRID_TB;
            half = n / 2;
            if (p >= NUM_PHASES - 2 || p == 1)
                sender_idle_pct = 0;
            else
                sender_idle_pct = 10 * $urandom_range(0, 5);
            if (p >= NUM_PHASES - 2)
                stall_pct = 0;
            else
                stall_pct = 10 * $urandom_range(0, 5);
            for (int i = 0; i < POINTS_PER_PHASE; i++)
            begin
                // Long receiver hold-off while words keep coming
                if (p == 1 && i == 5)
                    hold_request = 1'b1;
                send_point(pick_coord(half), pick_coord(half), pick_coord(half));
            end
            drain();
        end

        leftover = sb.pending();
        if (sb.errors == 0 && leftover == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gpf_pkg.sv
rtl/gpf_pipe_ctrl.sv
rtl/gpf_index.sv
rtl/gpf_sincos.sv
rtl/grid_phase_factor_sincos_core.sv
verif/tb_grid_phase_factor_sincos_core.sv
